@@ hdl/two_class_priority_queue_core_assert.svh @@
// assertion macros used by the checker file
`ifndef TWO_CLASS_PRIORITY_QUEUE_CORE_ASSERT_SVH
`define TWO_CLASS_PRIORITY_QUEUE_CORE_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define TCPQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// antecedent implies consequent in the following cycle
`define TCPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

@@ hdl/tcpq_pkg.sv @@
// types and constants of the two-class priority queue
package tcpq_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int ID_BITS     = 16;
	localparam int OCC_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int REM_W       = 5;
	localparam int BATCH_W     = 3;
	localparam int MAX_BATCH   = 4;
	localparam int CMD_W       = 2;
	localparam int STATUS_W    = 2;

	localparam logic [BATCH_W-1:0] BATCH_RESET = BATCH_W'(4);

	localparam logic [CMD_W-1:0] CMD_REGISTER = 2'd0;
	localparam logic [CMD_W-1:0] CMD_REMOVE   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CALL     = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd2;
	localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd3;

	typedef enum logic [1:0] {
		OP_HOLD,
		OP_INSERT,
		OP_REMOVE,
		OP_POP
	} op_t;

	typedef struct packed {
		op_t                op;
		logic [ID_BITS-1:0] id;
		logic               fast;
	} cell_cmd_t;

	typedef struct packed {
		logic               valid;
		logic               fast;
		logic [ID_BITS-1:0] id;
	} entry_t;

	// ripple signals along the chain
	typedef struct packed {
		logic keep;
		logic seen;
	} link_t;

endpackage

@@ hdl/tcpq_if.sv @@
// handshake channels for command words and result words
interface tcpq_req_if;
	logic                               valid;
	logic                               ready;
	logic [tcpq_pkg::CMD_W-1:0]         cmd;
	logic [tcpq_pkg::ID_BITS-1:0]       ticket_id;
	logic                               express;

	modport source (output valid, cmd, ticket_id, express, input ready);
	modport sink (input valid, cmd, ticket_id, express, output ready);
endinterface

interface tcpq_rsp_if;
	logic                               valid;
	logic                               ready;
	logic [tcpq_pkg::STATUS_W-1:0]      status;
	logic [tcpq_pkg::ID_BITS-1:0]       called_id;
	logic                               called_fast;
	logic                               last;
	logic [tcpq_pkg::REM_W-1:0]         remaining;

	modport source (output valid, status, called_id, called_fast, last, remaining,
		input ready);
	modport sink (input valid, status, called_id, called_fast, last, remaining,
		output ready);
endinterface

@@ hdl/tcpq_cell.sv @@
// one slot of the queue chain
module tcpq_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  tcpq_pkg::cell_cmd_t cmd,
	input  tcpq_pkg::entry_t    prev_entry,
	input  tcpq_pkg::entry_t    next_entry,
	input  tcpq_pkg::link_t     link_in,
	output tcpq_pkg::link_t     link_out,
	output tcpq_pkg::entry_t    entry
);

	logic                         valid_q;
	logic                         fast_q;
	logic [tcpq_pkg::ID_BITS-1:0] id_q;
	logic                         keep;
	logic                         match;
	tcpq_pkg::entry_t             entry_d;

	// slot stays put on insert when it holds an entry ahead of the new one
	assign keep  = valid_q && (cmd.fast ? fast_q : 1'b1);
	assign match = valid_q && (id_q == cmd.id);

	assign link_out.keep = keep;
	assign link_out.seen = link_in.seen | match;

	assign entry.valid = valid_q;
	assign entry.fast  = fast_q;
	assign entry.id    = id_q;

	always_comb begin
		entry_d = entry;
		case (cmd.op)
			tcpq_pkg::OP_INSERT: begin
				if (!keep) begin
					if (link_in.keep) begin
						entry_d.valid = 1'b1;
						entry_d.fast  = cmd.fast;
						entry_d.id    = cmd.id;
					end else begin
						entry_d = prev_entry;
					end
				end
			end
			tcpq_pkg::OP_REMOVE: begin
				if (link_in.seen || match) begin
					entry_d = next_entry;
				end
			end
			tcpq_pkg::OP_POP: begin
				entry_d = next_entry;
			end
			default: begin
				entry_d = entry;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= entry_d.valid;
		end
	end

	always_ff @(posedge clk) begin
		fast_q <= entry_d.fast;
		id_q   <= entry_d.id;
	end

endmodule

@@ hdl/two_class_priority_queue_core.sv @@
// two-class priority queue of ticket ids: command sequencer and slot chain
//
// Commands arrive as words on the req channel (cmd, ticket_id, express) and
// results leave as words on the rsp channel, both valid/ready handshakes.
// Entries sit packed at the front of a chain of slots, express ahead of
// regular, each class in arrival order. batch_size is written on cfg_we.
// Register and remove are done in the cycle of acceptance by one shift of
// the chain; their single result word shows in the next cycle, and with rsp
// ready held high a new command is taken every cycle.
// A call is accepted, then pops one entry per cycle from slot 0 while the
// result register is free, giving n result words (n at most four); the last word
// carries last = 1. Only one word at a time passes the result register.
// When rsp ready is low the result register holds its word and req ready
// drops until it is taken. Reset empties the queue, drops any word in flight
// and sets batch_size to four.
module two_class_priority_queue_core (
	input  logic                          clk,
	input  logic                          arst_n,
	tcpq_req_if.sink                      req,
	tcpq_rsp_if.source                    rsp,
	input  logic                          cfg_we,
	input  logic [tcpq_pkg::BATCH_W-1:0]  cfg_data
);

	typedef enum logic {
		S_IDLE,
		S_CALL
	} state_t;

	state_t                            state_q, state_d;
	logic [tcpq_pkg::OCC_W-1:0]        occ_q, occ_d;
	logic [tcpq_pkg::BATCH_W-1:0]      left_q, left_d;
	logic [tcpq_pkg::BATCH_W-1:0]      batch_q;
	logic                              rsp_valid_q, rsp_valid_d;
	logic [tcpq_pkg::STATUS_W-1:0]     status_q, status_d;
	logic [tcpq_pkg::ID_BITS-1:0]      called_id_q, called_id_d;
	logic                              called_fast_q, called_fast_d;
	logic                              last_q, last_d;
	logic [tcpq_pkg::OCC_W-1:0]        remaining_q, remaining_d;

	logic                              out_free;
	logic                              accept;
	logic [tcpq_pkg::BATCH_W-1:0]      n_batch;
	logic [tcpq_pkg::BATCH_W-1:0]      n_eff;
	tcpq_pkg::cell_cmd_t               cell_cmd;
	tcpq_pkg::entry_t                  ent [tcpq_pkg::QUEUE_DEPTH];
	tcpq_pkg::link_t                   link [tcpq_pkg::QUEUE_DEPTH + 1];

	assign out_free  = !rsp_valid_q || rsp.ready;
	assign req.ready = (state_q == S_IDLE) && out_free;
	assign accept    = req.valid && req.ready;

	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = status_q;
	assign rsp.called_id   = called_id_q;
	assign rsp.called_fast = called_fast_q;
	assign rsp.last        = last_q;
	assign rsp.remaining   = tcpq_pkg::REM_W'(remaining_q);

	// slot chain
	assign link[0].keep = 1'b1;
	assign link[0].seen = 1'b0;

	for (genvar i = 0; i < tcpq_pkg::QUEUE_DEPTH; i++) begin : g_cell
		tcpq_pkg::entry_t prev_e;
		tcpq_pkg::entry_t next_e;

		if (i == 0) begin : g_first
			assign prev_e = '0;
		end else begin : g_inner_p
			assign prev_e = ent[i-1];
		end

		if (i == tcpq_pkg::QUEUE_DEPTH - 1) begin : g_end
			assign next_e = '0;
		end else begin : g_inner_n
			assign next_e = ent[i+1];
		end

		tcpq_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cell_cmd),
			.prev_entry (prev_e),
			.next_entry (next_e),
			.link_in    (link[i]),
			.link_out   (link[i+1]),
			.entry      (ent[i])
		);
	end

	// batch length clamped to 1..MAX_BATCH and to the occupancy
	always_comb begin
		if (batch_q == '0) begin
			n_batch = tcpq_pkg::BATCH_W'(1);
		end else if (batch_q > tcpq_pkg::BATCH_W'(tcpq_pkg::MAX_BATCH)) begin
			n_batch = tcpq_pkg::BATCH_W'(tcpq_pkg::MAX_BATCH);
		end else begin
			n_batch = batch_q;
		end
		if (tcpq_pkg::OCC_W'(n_batch) > occ_q) begin
			n_eff = occ_q[tcpq_pkg::BATCH_W-1:0];
		end else begin
			n_eff = n_batch;
		end
	end

	always_comb begin
		state_d       = state_q;
		occ_d         = occ_q;
		left_d        = left_q;
		rsp_valid_d   = rsp_valid_q && !rsp.ready;
		status_d      = status_q;
		called_id_d   = called_id_q;
		called_fast_d = called_fast_q;
		last_d        = last_q;
		remaining_d   = remaining_q;
		cell_cmd.op   = tcpq_pkg::OP_HOLD;
		cell_cmd.id   = req.ticket_id;
		cell_cmd.fast = req.express;

		if (accept) begin
			called_id_d   = '0;
			called_fast_d = 1'b0;
			last_d        = 1'b1;
			remaining_d   = occ_q;
			case (req.cmd)
				tcpq_pkg::CMD_REGISTER: begin
					rsp_valid_d = 1'b1;
					if (occ_q == tcpq_pkg::OCC_W'(tcpq_pkg::QUEUE_DEPTH)) begin
						status_d = tcpq_pkg::ST_FULL;
					end else begin
						cell_cmd.op = tcpq_pkg::OP_INSERT;
						status_d    = tcpq_pkg::ST_OK;
						occ_d       = occ_q + 1'b1;
						remaining_d = occ_q + 1'b1;
					end
				end
				tcpq_pkg::CMD_REMOVE: begin
					rsp_valid_d = 1'b1;
					cell_cmd.op = tcpq_pkg::OP_REMOVE;
					if (link[tcpq_pkg::QUEUE_DEPTH].seen) begin
						status_d    = tcpq_pkg::ST_OK;
						occ_d       = occ_q - 1'b1;
						remaining_d = occ_q - 1'b1;
					end else begin
						status_d = tcpq_pkg::ST_NOTFOUND;
					end
				end
				tcpq_pkg::CMD_CALL: begin
					if (occ_q == '0) begin
						rsp_valid_d = 1'b1;
						status_d    = tcpq_pkg::ST_EMPTY;
					end else begin
						state_d = S_CALL;
						left_d  = n_eff;
					end
				end
				default: begin
					state_d = S_IDLE;
				end
			endcase
		end else if (state_q == S_CALL && out_free) begin
			cell_cmd.op   = tcpq_pkg::OP_POP;
			rsp_valid_d   = 1'b1;
			status_d      = tcpq_pkg::ST_OK;
			called_id_d   = ent[0].id;
			called_fast_d = ent[0].fast;
			last_d        = (left_q == tcpq_pkg::BATCH_W'(1));
			occ_d         = occ_q - 1'b1;
			remaining_d   = occ_q - 1'b1;
			left_d        = left_q - 1'b1;
			if (left_q == tcpq_pkg::BATCH_W'(1)) begin
				state_d = S_IDLE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			occ_q         <= '0;
			left_q        <= '0;
			batch_q       <= tcpq_pkg::BATCH_RESET;
			rsp_valid_q   <= 1'b0;
			status_q      <= tcpq_pkg::ST_OK;
			called_id_q   <= '0;
			called_fast_q <= 1'b0;
			last_q        <= 1'b0;
			remaining_q   <= '0;
		end else begin
			state_q       <= state_d;
			occ_q         <= occ_d;
			left_q        <= left_d;
			if (cfg_we) begin
				batch_q <= cfg_data;
			end
			rsp_valid_q   <= rsp_valid_d;
			status_q      <= status_d;
			called_id_q   <= called_id_d;
			called_fast_q <= called_fast_d;
			last_q        <= last_d;
			remaining_q   <= remaining_d;
		end
	end

endmodule

@@ hdl/tcpq_checker.sv @@
// port-level checks on the queue core and their binding
`include "two_class_priority_queue_core_assert.svh"

module tcpq_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           rsp_valid,
	input  logic                           rsp_ready,
	input  logic [tcpq_pkg::STATUS_W-1:0]  rsp_status,
	input  logic [tcpq_pkg::ID_BITS-1:0]   rsp_called_id,
	input  logic                           rsp_called_fast,
	input  logic                           rsp_last,
	input  logic [tcpq_pkg::REM_W-1:0]     rsp_remaining
);

	// a stalled word stays valid and holds its status, id, last and remaining
	`TCPQ_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_called_id) && $stable(rsp_remaining) && $stable(rsp_last))

	// error words are single, end the command and carry no ticket
	`TCPQ_ASSERT_NOW(a_err_word, clk, arst_n, rsp_valid && rsp_status != tcpq_pkg::ST_OK, rsp_last && rsp_called_id == '0 && !rsp_called_fast)

	// full only with every slot taken
	`TCPQ_ASSERT_NOW(a_full_count, clk, arst_n, rsp_valid && rsp_status == tcpq_pkg::ST_FULL, rsp_remaining == tcpq_pkg::REM_W'(tcpq_pkg::QUEUE_DEPTH))

	// empty only with no slot taken
	`TCPQ_ASSERT_NOW(a_empty_count, clk, arst_n, rsp_valid && rsp_status == tcpq_pkg::ST_EMPTY, rsp_remaining == '0)

endmodule

bind two_class_priority_queue_core tcpq_checker u_tcpq_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_status      (rsp.status),
	.rsp_called_id   (rsp.called_id),
	.rsp_called_fast (rsp.called_fast),
	.rsp_last        (rsp.last),
	.rsp_remaining   (rsp.remaining)
);

@@ test/tb.sv @@
// testbench for the two-class priority queue core: ticket-line model, random stalls, checks
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [tcpq_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam int LONG_HOLD = 300;
	localparam int SETTLE = 8;
	localparam int CYCLE_LIMIT = 200000;

	typedef struct packed {
		logic [tcpq_pkg::ID_BITS-1:0] id;
		logic                         fast;
	} ticket_t;

	typedef struct packed {
		logic [tcpq_pkg::STATUS_W-1:0] status;
		logic [tcpq_pkg::ID_BITS-1:0]  called_id;
		logic                          called_fast;
		logic                          last;
		logic [tcpq_pkg::REM_W-1:0]    remaining;
	} word_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [tcpq_pkg::BATCH_W-1:0] cfg_data;

	tcpq_req_if req();
	tcpq_rsp_if rsp();

	two_class_priority_queue_core DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.rsp      (rsp),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data)
	);

	ticket_t ticket_line[$];
	word_t due_words[$];
	logic [tcpq_pkg::BATCH_W-1:0] batch_cfg;
	int errors = 0;
	int cycles = 0;
	int hold_asked = 0;
	int burst_left = 0;
	bit tx_idle = 1'b1;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("tb: FAIL");
			$finish;
		end
	end

	function automatic void post_word(logic [tcpq_pkg::STATUS_W-1:0] status,
		logic [tcpq_pkg::ID_BITS-1:0] id, logic fast, logic last);
		word_t w;
		w.status = status;
		w.called_id = id;
		w.called_fast = fast;
		w.last = last;
		w.remaining = tcpq_pkg::REM_W'(ticket_line.size());
		due_words.push_back(w);
	endfunction

	// queue behaviour for one accepted command word
	function automatic void serve_ticket_cmd(logic [tcpq_pkg::CMD_W-1:0] cmd,
		logic [tcpq_pkg::ID_BITS-1:0] id, logic fast);
		int pos;
		int hit;
		int n;
		ticket_t t;
		case (cmd)
			tcpq_pkg::CMD_REGISTER: begin
				if (ticket_line.size() >= tcpq_pkg::QUEUE_DEPTH) begin
					post_word(tcpq_pkg::ST_FULL, '0, 1'b0, 1'b1);
				end else begin
					pos = ticket_line.size();
					if (fast) begin
						for (int i = 0; i < ticket_line.size(); i++)
							if (pos == ticket_line.size() && !ticket_line[i].fast)
								pos = i;
					end
					t.id = id;
					t.fast = fast;
					ticket_line.insert(pos, t);
					post_word(tcpq_pkg::ST_OK, '0, 1'b0, 1'b1);
				end
			end
			tcpq_pkg::CMD_REMOVE: begin
				hit = -1;
				for (int i = 0; i < ticket_line.size(); i++)
					if (hit < 0 && ticket_line[i].id == id)
						hit = i;
				if (hit >= 0) begin
					ticket_line.delete(hit);
					post_word(tcpq_pkg::ST_OK, '0, 1'b0, 1'b1);
				end else begin
					post_word(tcpq_pkg::ST_NOTFOUND, '0, 1'b0, 1'b1);
				end
			end
			tcpq_pkg::CMD_CALL: begin
				if (ticket_line.size() == 0) begin
					post_word(tcpq_pkg::ST_EMPTY, '0, 1'b0, 1'b1);
				end else begin
					n = batch_cfg;
					if (n == 0)
						n = 1;
					if (n > tcpq_pkg::MAX_BATCH)
						n = tcpq_pkg::MAX_BATCH;
					if (n > ticket_line.size())
						n = ticket_line.size();
					for (int k = 0; k < n; k++) begin
						t = ticket_line.pop_front();
						post_word(tcpq_pkg::ST_OK, t.id, t.fast, k == n - 1);
					end
				end
			end
			default: ;
		endcase
	endfunction

	task automatic send_word(logic [tcpq_pkg::CMD_W-1:0] cmd,
		logic [tcpq_pkg::ID_BITS-1:0] id, logic fast);
		int gap;
		if (burst_left == 0) begin
			gap = tx_idle ? $urandom_range(0, 6) : 0;
			burst_left = $urandom_range(1, 12);
			if (gap > 0) begin
				req.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		req.valid <= 1'b1;
		req.cmd <= cmd;
		req.ticket_id <= id;
		req.express <= fast;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		burst_left--;
		serve_ticket_cmd(cmd, id, fast);
	endtask

	task automatic drain_results();
		req.valid <= 1'b0;
		@(posedge clk);
		while (due_words.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_batch(logic [tcpq_pkg::BATCH_W-1:0] size);
		drain_results();
		repeat (SETTLE) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_data <= size;
		@(posedge clk);
		cfg_we <= 1'b0;
		batch_cfg = size;
	endtask

	function automatic logic [tcpq_pkg::ID_BITS-1:0] pick_id();
		case ($urandom_range(0, 3))
			0: pick_id = tcpq_pkg::ID_BITS'($urandom_range(0, 7));
			1: begin
				case ($urandom_range(0, 3))
					0: pick_id = '0;
					1: pick_id = '1;
					2: pick_id = {1'b1, {(tcpq_pkg::ID_BITS-1){1'b0}}};
					default: pick_id = {1'b0, {(tcpq_pkg::ID_BITS-1){1'b1}}};
				endcase
			end
			default: pick_id = tcpq_pkg::ID_BITS'($urandom);
		endcase
	endfunction

	function automatic logic [tcpq_pkg::ID_BITS-1:0] pick_remove_id();
		if (ticket_line.size() != 0 && $urandom_range(0, 9) < 7)
			pick_remove_id = ticket_line[$urandom_range(0, ticket_line.size() - 1)].id;
		else
			pick_remove_id = pick_id();
	endfunction

	task automatic send_random_word(int w_reg, int w_rem, int w_call, ref int served);
		int r;
		if ($urandom_range(0, 39) == 0) begin
			send_word(CMD_UNUSED, tcpq_pkg::ID_BITS'($urandom), 1'($urandom_range(0, 1)));
		end else begin
			r = $urandom_range(0, w_reg + w_rem + w_call - 1);
			if (r < w_reg)
				send_word(tcpq_pkg::CMD_REGISTER, pick_id(), 1'($urandom_range(0, 1)));
			else if (r < w_reg + w_rem)
				send_word(tcpq_pkg::CMD_REMOVE, pick_remove_id(), 1'($urandom_range(0, 1)));
			else
				send_word(tcpq_pkg::CMD_CALL, tcpq_pkg::ID_BITS'($urandom),
					1'($urandom_range(0, 1)));
			served++;
		end
	endtask

	task automatic test_empty_queue();
		send_word(tcpq_pkg::CMD_CALL, '0, 1'b0);
		send_word(tcpq_pkg::CMD_REMOVE, '1, 1'b1);
		send_word(CMD_UNUSED, 16'h1234, 1'b1);
		send_word(tcpq_pkg::CMD_CALL, '1, 1'b1);
	endtask

	task automatic test_class_order();
		send_word(tcpq_pkg::CMD_REGISTER, 16'h0000, 1'b0);
		send_word(tcpq_pkg::CMD_REGISTER, 16'hFFFF, 1'b1);
		send_word(tcpq_pkg::CMD_REGISTER, 16'hA5A5, 1'b0);
		send_word(tcpq_pkg::CMD_REGISTER, 16'h5A5A, 1'b1);
		send_word(tcpq_pkg::CMD_REGISTER, 16'h1234, 1'b0);
		send_word(tcpq_pkg::CMD_REGISTER, 16'h1234, 1'b1);
		send_word(tcpq_pkg::CMD_REMOVE, 16'hBEEF, 1'b0);
		send_word(tcpq_pkg::CMD_REMOVE, 16'h1234, 1'b0);
		send_word(tcpq_pkg::CMD_CALL, '0, 1'b0);
		send_word(tcpq_pkg::CMD_CALL, '0, 1'b0);
		send_word(tcpq_pkg::CMD_CALL, '0, 1'b0);
		// removing the only entry
		send_word(tcpq_pkg::CMD_REGISTER, 16'h0042, 1'b1);
		send_word(tcpq_pkg::CMD_REMOVE, 16'h0042, 1'b0);
		send_word(tcpq_pkg::CMD_CALL, '0, 1'b0);
	endtask

	task automatic test_batch_sizes();
		logic [tcpq_pkg::BATCH_W-1:0] sizes [8];
		int served;
		served = 0;
		sizes = '{3'd0, 3'd1, 3'd2, 3'd3, 3'd5, 3'd6, 3'd7, 3'd4};
		foreach (sizes[i]) begin
			set_batch(sizes[i]);
			repeat (5) send_random_word(1, 0, 0, served);
			send_word(tcpq_pkg::CMD_CALL, '0, 1'b0);
			send_word(tcpq_pkg::CMD_CALL, '0, 1'b0);
		end
	endtask

	task automatic test_full_queue();
		while (ticket_line.size() < tcpq_pkg::QUEUE_DEPTH)
			send_word(tcpq_pkg::CMD_REGISTER, pick_id(), 1'($urandom_range(0, 1)));
		send_word(tcpq_pkg::CMD_REGISTER, '1, 1'b1);
		send_word(tcpq_pkg::CMD_REGISTER, '0, 1'b0);
		send_word(tcpq_pkg::CMD_REMOVE, pick_remove_id(), 1'b0);
		send_word(tcpq_pkg::CMD_REGISTER, 16'hC3C3, 1'b1);
		send_word(tcpq_pkg::CMD_REGISTER, 16'h3C3C, 1'b0);
		while (ticket_line.size() != 0)
			send_word(tcpq_pkg::CMD_CALL, '0, 1'b0);
		send_word(tcpq_pkg::CMD_CALL, '0, 1'b0);
	endtask

	task automatic test_backpressure();
		int served;
		served = 0;
		tx_idle = 1'b0;
		hold_asked <= hold_asked + 1;
		repeat (40) send_random_word(4, 1, 3, served);
		drain_results();
		tx_idle = 1'b1;
	endtask

	task automatic test_random_mix();
		int served;
		int seg;
		int profile;
		served = 0;
		while (served < 150) begin
			profile = $urandom_range(0, 3);
			tx_idle = ($urandom_range(0, 3) != 0);
			seg = $urandom_range(20, 40);
			repeat (seg) begin
				case (profile)
					0: send_random_word(6, 2, 1, served);
					1: send_random_word(3, 2, 2, served);
					2: send_random_word(1, 1, 3, served);
					default: send_random_word(3, 4, 1, served);
				endcase
			end
			case ($urandom_range(0, 2))
				0: set_batch(tcpq_pkg::BATCH_W'($urandom_range(0, 7)));
				1: drain_results();
				default: ;
			endcase
		end
		tx_idle = 1'b1;
	endtask

	// result side: stall pattern of its own, long hold on request
	initial begin
		int hold_left;
		int hold_seen;
		int tick;
		logic [7:0] stall_mask;
		hold_left = 0;
		hold_seen = 0;
		tick = 0;
		stall_mask = 8'b1011_0110;
		rsp.ready = 1'b0;
		forever begin
			@(posedge clk);
			tick++;
			if (hold_asked != hold_seen) begin
				hold_seen = hold_asked;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp.ready <= 1'b0;
			end else begin
				case ((tick / 97) % 4)
					0: rsp.ready <= 1'b1;
					1: rsp.ready <= 1'($urandom_range(0, 1));
					2: rsp.ready <= ($urandom_range(0, 3) != 0);
					default: begin
						stall_mask = {stall_mask[6:0], stall_mask[7]};
						rsp.ready <= stall_mask[0];
					end
				endcase
			end
		end
	end

	task automatic check_field(string name, int want, int got);
		if (want != got) begin
			$display("%0t ns: %s expected %0h, got %0h", $time, name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		word_t want;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (due_words.size() == 0) begin
				$display("%0t ns: word with nothing expected, got status %0d id %0h last %0d",
					$time, rsp.status, rsp.called_id, rsp.last);
				errors++;
			end else begin
				want = due_words.pop_front();
				check_field("status", want.status, rsp.status);
				check_field("called_id", want.called_id, rsp.called_id);
				check_field("called_fast", want.called_fast, rsp.called_fast);
				check_field("last", want.last, rsp.last);
				check_field("remaining", want.remaining, rsp.remaining);
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.cmd = tcpq_pkg::CMD_REGISTER;
		req.ticket_id = '0;
		req.express = 1'b0;
		cfg_we = 1'b0;
		cfg_data = tcpq_pkg::BATCH_RESET;
		batch_cfg = tcpq_pkg::BATCH_RESET;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_queue();
		test_class_order();
		test_batch_sizes();
		test_full_queue();
		test_backpressure();
		test_random_mix();

		drain_results();
		repeat (20) @(posedge clk);
		if (errors == 0 && due_words.size() == 0) begin
			$display("tb: PASS");
		end else begin
			$display("tb: FAIL");
		end
		$finish;
	end

endmodule
